[hdl/sads_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the two-stacks-in-one-store block.
// Request codes, status codes and the controller-to-datapath command struct.
// No dependencies.
package sads_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned VALUE_W  = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH_A = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_B = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_A  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_B  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic exec;   // request accepted: update depths, write store
    logic rd;     // read both top entries
    logic load;   // load the result register
  } dp_cmd_t;

endpackage

[hdl/sads_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences accept, top read and result load for each request.
// Depends on sads_pkg.
module sads_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sads_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/sads_datapath.sv]
`timescale 1ns / 1ps
// Datapath: stack depths, shared store with two registered read ports,
// and the result register. Depends on sads_pkg.
module sads_datapath #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sads_pkg::dp_cmd_t                cmd_i,
  input  logic [sads_pkg::CMD_W-1:0]       command_i,
  input  logic [sads_pkg::VALUE_W-1:0]     push_value_i,
  output logic [sads_pkg::STATUS_W-1:0]    status_o,
  output logic [sads_pkg::COUNT_W-1:0]     count_a_o,
  output logic [sads_pkg::COUNT_W-1:0]     count_b_o,
  output logic                             store_full_o,
  output logic [sads_pkg::VALUE_W-1:0]     top_a_o,
  output logic [sads_pkg::VALUE_W-1:0]     top_b_o
);

  localparam int unsigned DEPTH_W = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned EXT_W   =
    (WORD_BITS > sads_pkg::VALUE_W) ? WORD_BITS : sads_pkg::VALUE_W;

  logic [WORD_BITS-1:0] store_q [CAPACITY];

  logic [DEPTH_W-1:0]            depth_a_q, depth_a_d;
  logic [DEPTH_W-1:0]            depth_b_q, depth_b_d;
  logic [sads_pkg::STATUS_W-1:0] status_q, status_d;
  logic [WORD_BITS-1:0]          rd_a_q, rd_b_q;
  logic [DEPTH_W:0]              total;
  logic                          full;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             rd_addr_a, rd_addr_b;
  logic [DEPTH_W-1:0]            depth_a_m1, cap_m_b;
  logic [EXT_W-1:0]              push_ext, top_a_ext, top_b_ext;
  logic [WORD_BITS-1:0]          wr_data;

  logic [sads_pkg::STATUS_W-1:0] status_out_q;
  logic [sads_pkg::COUNT_W-1:0]  count_a_q, count_b_q;
  logic                          full_out_q;
  logic [sads_pkg::VALUE_W-1:0]  top_a_q, top_b_q;

  assign total    = {1'b0, depth_a_q} + {1'b0, depth_b_q};
  assign full     = (total >= (DEPTH_W + 1)'(CAPACITY));
  assign push_ext = EXT_W'(push_value_i);
  assign wr_data  = push_ext[WORD_BITS-1:0];

  always_comb begin
    depth_a_d = depth_a_q;
    depth_b_d = depth_b_q;
    status_d  = sads_pkg::ST_OK;
    wr_en     = 1'b0;
    wr_addr   = depth_a_q[ADDR_W-1:0];
    if (command_i inside {sads_pkg::CMD_PUSH_A, sads_pkg::CMD_PUSH_B}) begin
      if (full) begin
        status_d = sads_pkg::ST_OVER;
      end else if (command_i == sads_pkg::CMD_PUSH_A) begin
        wr_en     = 1'b1;
        wr_addr   = depth_a_q[ADDR_W-1:0];
        depth_a_d = depth_a_q + 1'b1;
      end else begin
        wr_en     = 1'b1;
        wr_addr   = ADDR_W'(CAPACITY - 1) - depth_b_q[ADDR_W-1:0];
        depth_b_d = depth_b_q + 1'b1;
      end
    end else if (command_i == sads_pkg::CMD_POP_A) begin
      if (depth_a_q == '0) begin
        status_d = sads_pkg::ST_UNDER;
      end else begin
        depth_a_d = depth_a_q - 1'b1;
      end
    end else if (command_i == sads_pkg::CMD_POP_B) begin
      if (depth_b_q == '0) begin
        status_d = sads_pkg::ST_UNDER;
      end else begin
        depth_b_d = depth_b_q - 1'b1;
      end
    end
  end

  // Peek and unused codes fall through with status ok.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_a_q <= '0;
      depth_b_q <= '0;
    end else if (cmd_i.exec) begin
      depth_a_q <= depth_a_d;
      depth_b_q <= depth_b_d;
    end
  end

  // Empty-stack addresses read a don't-care entry; masked at load.
  assign depth_a_m1 = depth_a_q - 1'b1;
  assign cap_m_b    = DEPTH_W'(CAPACITY) - depth_b_q;
  assign rd_addr_a  = depth_a_m1[ADDR_W-1:0];
  assign rd_addr_b  = cap_m_b[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      if (wr_en) begin
        store_q[wr_addr] <= wr_data;
      end
    end
    if (cmd_i.rd) begin
      rd_a_q <= store_q[rd_addr_a];
      rd_b_q <= store_q[rd_addr_b];
    end
  end

  assign top_a_ext = EXT_W'(rd_a_q);
  assign top_b_ext = EXT_W'(rd_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_out_q <= status_q;
      count_a_q    <= sads_pkg::COUNT_W'(depth_a_q);
      count_b_q    <= sads_pkg::COUNT_W'(depth_b_q);
      full_out_q   <= full;
      top_a_q      <= (depth_a_q == '0) ? '0 : top_a_ext[sads_pkg::VALUE_W-1:0];
      top_b_q      <= (depth_b_q == '0) ? '0 : top_b_ext[sads_pkg::VALUE_W-1:0];
    end
  end

  assign status_o     = status_out_q;
  assign count_a_o    = count_a_q;
  assign count_b_o    = count_b_q;
  assign store_full_o = full_out_q;
  assign top_a_o      = top_a_q;
  assign top_b_o      = top_b_q;

endmodule

[hdl/shared_array_dual_stack_top.sv]
`timescale 1ns / 1ps
// Top level of the two-stacks-in-one-store block: controller plus datapath.
// Depends on sads_pkg, sads_ctrl and sads_datapath.
//
// Two stacks share one store of CAPACITY words: stack A grows up from entry 0,
// stack B grows down from the last entry. Each request is push A, push B,
// pop A, pop B or peek, and returns one result: status (ok, underflow on an
// empty pop, overflow on a full push, in which cases nothing changes), both
// depths, a full flag and the top word of each stack (0 when empty). One
// request is handled at a time, in order: accepting it updates the depths and
// writes the store, then both tops are read through the store's registered
// read ports, then the result register is loaded once the output is free.
// A new request is accepted while an earlier result still waits in the output
// register.
module shared_array_dual_stack_top #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sads_pkg::CMD_W-1:0]    command_i,
  input  logic [sads_pkg::VALUE_W-1:0]  push_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sads_pkg::STATUS_W-1:0] status_o,
  output logic [sads_pkg::COUNT_W-1:0]  count_a_o,
  output logic [sads_pkg::COUNT_W-1:0]  count_b_o,
  output logic                          store_full_o,
  output logic [sads_pkg::VALUE_W-1:0]  top_a_o,
  output logic [sads_pkg::VALUE_W-1:0]  top_b_o
);

  sads_pkg::dp_cmd_t cmd;

  sads_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sads_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .status_o     (status_o),
    .count_a_o    (count_a_o),
    .count_b_o    (count_b_o),
    .store_full_o (store_full_o),
    .top_a_o      (top_a_o),
    .top_b_o      (top_b_o)
  );

endmodule

[bench/tb_shared_array_dual_stack_top.sv]
`timescale 1ns / 1ps
// Testbench for shared_array_dual_stack_top: random and directed stack requests against
// a scoreboard class that mirrors both stacks. Depends on sads_pkg and the block's RTL.
module tb_shared_array_dual_stack_top;

  localparam int unsigned CAP      = 16;
  localparam int unsigned N_RANDOM = 1200;
  localparam int unsigned LIMIT    = 400000;

  typedef struct packed {
    logic [sads_pkg::STATUS_W-1:0] status;
    logic [sads_pkg::COUNT_W-1:0]  count_a;
    logic [sads_pkg::COUNT_W-1:0]  count_b;
    logic                          full;
    logic [sads_pkg::VALUE_W-1:0]  top_a;
    logic [sads_pkg::VALUE_W-1:0]  top_b;
  } stack_result_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_e;

  class stack_scoreboard;
    logic [sads_pkg::VALUE_W-1:0] words[CAP];
    int unsigned depth_a;
    int unsigned depth_b;
    stack_result_t expected_q[$];
    int errors;

    function new();
      foreach (words[i]) words[i] = '0;
      depth_a = 0;
      depth_b = 0;
      errors  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [sads_pkg::CMD_W-1:0] cmd,
                               logic [sads_pkg::VALUE_W-1:0] val);
      stack_result_t r;
      logic is_full;
      is_full  = (depth_a + depth_b) >= CAP;
      r.status = sads_pkg::ST_OK;
      case (cmd)
        sads_pkg::CMD_PUSH_A, sads_pkg::CMD_PUSH_B: begin
          if (is_full) begin
            r.status = sads_pkg::ST_OVER;
          end else if (cmd == sads_pkg::CMD_PUSH_A) begin
            words[depth_a] = val;
            depth_a++;
          end else begin
            words[CAP - 1 - depth_b] = val;
            depth_b++;
          end
        end
        sads_pkg::CMD_POP_A: begin
          if (depth_a == 0) r.status = sads_pkg::ST_UNDER;
          else depth_a--;
        end
        sads_pkg::CMD_POP_B: begin
          if (depth_b == 0) r.status = sads_pkg::ST_UNDER;
          else depth_b--;
        end
        default: ;
      endcase
      r.count_a = depth_a[sads_pkg::COUNT_W-1:0];
      r.count_b = depth_b[sads_pkg::COUNT_W-1:0];
      r.full    = (depth_a + depth_b) >= CAP;
      r.top_a   = (depth_a > 0) ? words[depth_a - 1] : '0;
      r.top_b   = (depth_b > 0) ? words[CAP - depth_b] : '0;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [sads_pkg::VALUE_W-1:0] exp_v,
                                logic [sads_pkg::VALUE_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", sads_pkg::VALUE_W'(e.status), sads_pkg::VALUE_W'(got.status));
      compare_field("count_a", sads_pkg::VALUE_W'(e.count_a),
                    sads_pkg::VALUE_W'(got.count_a));
      compare_field("count_b", sads_pkg::VALUE_W'(e.count_b),
                    sads_pkg::VALUE_W'(got.count_b));
      compare_field("store_full", sads_pkg::VALUE_W'(e.full), sads_pkg::VALUE_W'(got.full));
      compare_field("top_a", e.top_a, got.top_a);
      compare_field("top_b", e.top_b, got.top_b);
    endfunction
  endclass

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          in_valid   = 1'b0;
  logic [sads_pkg::CMD_W-1:0]    command    = sads_pkg::CMD_PEEK;
  logic [sads_pkg::VALUE_W-1:0]  push_value = '0;
  logic                          out_stall  = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [sads_pkg::STATUS_W-1:0] status;
  logic [sads_pkg::COUNT_W-1:0]  count_a;
  logic [sads_pkg::COUNT_W-1:0]  count_b;
  logic                          store_full;
  logic [sads_pkg::VALUE_W-1:0]  top_a;
  logic [sads_pkg::VALUE_W-1:0]  top_b;

  stack_scoreboard sb;
  bit              no_idle = 1'b0;
  int unsigned     cycles  = 0;

  shared_array_dual_stack_top #(
    .CAPACITY (CAP),
    .WORD_BITS(sads_pkg::VALUE_W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .push_value_i(push_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .count_a_o   (count_a),
    .count_b_o   (count_b),
    .store_full_o(store_full),
    .top_a_o     (top_a),
    .top_b_o     (top_b)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input logic [sads_pkg::CMD_W-1:0] cmd,
                              input logic [sads_pkg::VALUE_W-1:0] val);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    push_value <= val;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(cmd, val);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [sads_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [sads_pkg::CMD_W-1:0] pick_command(mix_mode_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 40) return sads_pkg::CMD_PUSH_A;
        if (r < 80) return sads_pkg::CMD_PUSH_B;
        if (r < 90) return $urandom_range(0, 1) ? sads_pkg::CMD_POP_A : sads_pkg::CMD_POP_B;
      end
      MODE_DRAIN: begin
        if (r < 40) return sads_pkg::CMD_POP_A;
        if (r < 80) return sads_pkg::CMD_POP_B;
        if (r < 90) return $urandom_range(0, 1) ? sads_pkg::CMD_PUSH_A : sads_pkg::CMD_PUSH_B;
      end
      default: return sads_pkg::CMD_W'($urandom_range(0, 7));
    endcase
    return sads_pkg::CMD_W'($urandom_range(4, 7));
  endfunction

  // Result side; two long hold-offs let the block back up into its input.
  initial begin
    int unsigned w;
    int unsigned taken;
    stack_result_t got;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken == 300 || taken == 900) w = 120;
      else w = no_idle ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid);
      got = '{status, count_a, count_b, store_full, top_a, top_b};
      sb.check_result(got);
      taken++;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned phase;
    mix_mode_e   mode;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops, unused codes as peek, fill to the brim, overflow on both sides
    send_request(sads_pkg::CMD_PEEK, '1);
    send_request(sads_pkg::CMD_POP_A, '0);
    send_request(sads_pkg::CMD_POP_B, '0);
    send_request(3'd5, '1);
    send_request(3'd6, 32'h5a5a_5a5a);
    send_request(3'd7, 32'ha5a5_a5a5);
    send_request(sads_pkg::CMD_PUSH_A, '1);
    send_request(sads_pkg::CMD_PUSH_B, '0);
    for (int i = 0; i < CAP - 2; i++) begin
      send_request((i % 2) ? sads_pkg::CMD_PUSH_B : sads_pkg::CMD_PUSH_A, $urandom);
    end
    send_request(sads_pkg::CMD_PUSH_A, 32'hdead_beef);
    send_request(sads_pkg::CMD_PUSH_B, 32'hdead_beef);
    send_request(sads_pkg::CMD_POP_A, '0);
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    sent  = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      mode    = mix_mode_e'($urandom_range(0, 2));
      n       = $urandom_range(10, 60);
      no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
        send_request(pick_command(mode), pick_value());
      end
      sent += n;
      phase++;
      if (phase % 5 == 0) begin
        in_valid <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sads_pkg.sv
hdl/sads_ctrl.sv
hdl/sads_datapath.sv
hdl/shared_array_dual_stack_top.sv
bench/tb_shared_array_dual_stack_top.sv
